FILE: design/rational_normalize_divide_defines.svh
// assertion macros for the rational normalize and divide block
`ifndef RATIONAL_NORMALIZE_DIVIDE_DEFINES_SVH
`define RATIONAL_NORMALIZE_DIVIDE_DEFINES_SVH

// checked while out of reset
`define RND_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define RND_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/rnd_pkg.sv
// shared constants for the rational normalize and divide block
package rnd_pkg;

    localparam int OPERAND_BITS_DEF = 32;
    localparam int DATA_W           = 32;
    localparam int NUM_W            = 64;
    localparam int DEN_W            = 63;
    localparam int STATUS_W         = 2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd2;

    localparam logic KIND_NORM = 1'b0;
    localparam logic KIND_DIV  = 1'b1;

endpackage

FILE: design/rational_normalize_divide.sv
// rational normalize and divide: cross products, binary gcd and exact division
// a zero denominator or zero divisor gives an error result straight from idle, a zero numerator ends at the strip step
// otherwise the cross products when dividing, the strip and gcd steps, then two divisions of 2*OB-1 bits
// the gcd loop and both divisions share one subtractor, one bit or one step a cycle
// throughput is one beat at a time: busy stays high until the result strobe
// synchronous active-low reset returns the sequencer to idle and clears the strobe
`include "rational_normalize_divide_defines.svh"

module rational_normalize_divide
    import rnd_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_kind,
    input  logic signed [DATA_W-1:0]   i_a_num,
    input  logic signed [DATA_W-1:0]   i_a_den,
    input  logic signed [DATA_W-1:0]   i_b_num,
    input  logic signed [DATA_W-1:0]   i_b_den,
    output logic                       o_valid,
    output logic signed [NUM_W-1:0]    o_res_num,
    output logic        [DEN_W-1:0]    o_res_den,
    output logic        [STATUS_W-1:0] o_status
);

    localparam int OB = OPERAND_BITS;
    localparam int MW = 2 * OB - 1;
    localparam int SW = MW + 1;
    localparam int KW = $clog2(MW);
    localparam int CW = $clog2(MW);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL0  = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_STRIP = 3'd3;
    localparam logic [2:0] S_GCD   = 3'd4;
    localparam logic [2:0] S_DIVN  = 3'd5;
    localparam logic [2:0] S_DIVD  = 3'd6;

    logic [2:0]          r_state, n_state;
    logic                r_valid, n_valid;
    logic [OB-1:0]       r_an, r_ad, r_bn, r_bd, n_an, n_ad, n_bn, n_bd;
    logic                r_neg, n_neg;
    logic [MW-1:0]       r_nm, r_dm, r_x, r_y, r_rem;
    logic [MW-1:0]       n_nm, n_dm, n_x, n_y, n_rem;
    logic [KW-1:0]       r_k, n_k;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [NUM_W-1:0]    r_res_num, n_res_num;
    logic [DEN_W-1:0]    r_res_den, n_res_den;
    logic [STATUS_W-1:0] r_status, n_status;

    logic [OB-1:0]   a_num_v, a_den_v, b_num_v, b_den_v;
    logic [OB-1:0]   mag_an, mag_ad, mag_bn, mag_bd;
    logic            sgn_an, sgn_ad, sgn_bn, sgn_bd;
    logic [OB-1:0]   mul_a, mul_b;
    logic [2*OB-1:0] prod;
    logic [SW-1:0]   sub_a, sub_b;
    logic [SW:0]     sub_full;
    logic            borrow;
    logic            qbit;
    logic [MW-1:0]   quot;

    // operand magnitudes and signs from the low operand bits
    assign a_num_v = i_a_num[OB-1:0];
    assign a_den_v = i_a_den[OB-1:0];
    assign b_num_v = i_b_num[OB-1:0];
    assign b_den_v = i_b_den[OB-1:0];
    assign sgn_an  = a_num_v[OB-1];
    assign sgn_ad  = a_den_v[OB-1];
    assign sgn_bn  = b_num_v[OB-1];
    assign sgn_bd  = b_den_v[OB-1];
    assign mag_an  = sgn_an ? (~a_num_v + 1'b1) : a_num_v;
    assign mag_ad  = sgn_ad ? (~a_den_v + 1'b1) : a_den_v;
    assign mag_bn  = sgn_bn ? (~b_num_v + 1'b1) : b_num_v;
    assign mag_bd  = sgn_bd ? (~b_den_v + 1'b1) : b_den_v;

    // shared multiplier for the two cross products
    assign mul_a = (r_state == S_MUL0) ? r_an : r_ad;
    assign mul_b = (r_state == S_MUL0) ? r_bd : r_bn;
    assign prod  = mul_a * mul_b;

    // shared subtractor: gcd compare/subtract or one restoring division step
    always_comb begin
        if (r_state == S_GCD) begin
            sub_a = {1'b0, r_x};
        end else begin
            sub_a = {r_rem, r_x[MW-1]};
        end
        sub_b = {1'b0, r_y};
    end
    assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow   = sub_full[SW];
    assign qbit     = ~borrow;
    assign quot     = {r_x[MW-2:0], qbit};

    always_comb begin
        n_state   = r_state;
        n_valid   = 1'b0;
        n_an      = r_an;
        n_ad      = r_ad;
        n_bn      = r_bn;
        n_bd      = r_bd;
        n_neg     = r_neg;
        n_nm      = r_nm;
        n_dm      = r_dm;
        n_x       = r_x;
        n_y       = r_y;
        n_rem     = r_rem;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_res_num = r_res_num;
        n_res_den = r_res_den;
        n_status  = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_an  = mag_an;
                    n_ad  = mag_ad;
                    n_bn  = mag_bn;
                    n_bd  = mag_bd;
                    n_k   = '0;
                    n_res_num = '0;
                    n_res_den = DEN_W'(1);
                    if (i_kind == KIND_DIV) begin
                        n_neg = (sgn_an != sgn_bd) != (sgn_ad != sgn_bn);
                    end else begin
                        n_neg = sgn_an != sgn_ad;
                    end
                    priority if (mag_ad == '0 || (i_kind == KIND_DIV && mag_bd == '0)) begin
                        n_valid  = 1'b1;
                        n_status = ST_ZERO_DEN;
                    end else if (i_kind == KIND_DIV && mag_bn == '0) begin
                        n_valid  = 1'b1;
                        n_status = ST_DIV_ZERO;
                    end else if (i_kind == KIND_DIV) begin
                        n_state = S_MUL0;
                    end else begin
                        n_nm    = {{(MW-OB){1'b0}}, mag_an};
                        n_x     = {{(MW-OB){1'b0}}, mag_an};
                        n_dm    = {{(MW-OB){1'b0}}, mag_ad};
                        n_y     = {{(MW-OB){1'b0}}, mag_ad};
                        n_state = S_STRIP;
                    end
                end
            end
            S_MUL0: begin
                n_nm    = prod[MW-1:0];
                n_x     = prod[MW-1:0];
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_dm    = prod[MW-1:0];
                n_y     = prod[MW-1:0];
                n_state = S_STRIP;
            end
            S_STRIP: begin
                // common factors of two
                priority if (r_x == '0) begin
                    n_valid   = 1'b1;
                    n_status  = ST_OK;
                    n_res_num = '0;
                    n_res_den = DEN_W'(1);
                    n_state   = S_IDLE;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + 1'b1;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                priority if (r_x == '0) begin
                    n_y     = r_y << r_k;
                    n_x     = r_nm;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIVN;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (borrow) begin
                    n_x = r_y;
                    n_y = r_x;
                end else begin
                    n_x = sub_full[MW-1:0] >> 1;
                end
            end
            S_DIVN, S_DIVD: begin
                n_rem = borrow ? sub_a[MW-1:0] : sub_full[MW-1:0];
                n_x   = quot;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(MW-1)) begin
                    n_rem = '0;
                    n_cnt = '0;
                    if (r_state == S_DIVN) begin
                        n_nm    = quot;
                        n_x     = r_dm;
                        n_state = S_DIVD;
                    end else begin
                        n_valid   = 1'b1;
                        n_status  = ST_OK;
                        n_res_den = DEN_W'(quot);
                        n_res_num = r_neg ? (~{{(NUM_W-MW){1'b0}}, r_nm} + 1'b1)
                                          : {{(NUM_W-MW){1'b0}}, r_nm};
                        n_state   = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_an      <= n_an;
        r_ad      <= n_ad;
        r_bn      <= n_bn;
        r_bd      <= n_bd;
        r_neg     <= n_neg;
        r_nm      <= n_nm;
        r_dm      <= n_dm;
        r_x       <= n_x;
        r_y       <= n_y;
        r_rem     <= n_rem;
        r_k       <= n_k;
        r_cnt     <= n_cnt;
        r_res_num <= n_res_num;
        r_res_den <= n_res_den;
        r_status  <= n_status;
    end

    assign busy      = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_status  = r_status;

    `RND_ASSERT(a_strobe_idle, i_clk, i_rst_n, o_valid |-> !busy,
        "result strobe while busy")
    `RND_ASSERT(a_err_zero, i_clk, i_rst_n,
        (o_valid && o_status != ST_OK) |-> (o_res_num == '0 && o_res_den == DEN_W'(1)),
        "error result is not 0/1")
    `RND_ASSERT(a_den_pos, i_clk, i_rst_n, o_valid |-> (o_res_den != '0),
        "zero result denominator")
    `RND_ASSERT(a_div_nz, i_clk, i_rst_n, (r_state == S_DIVN || r_state == S_DIVD) |-> (r_y != '0),
        "division by zero gcd")
    `RND_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> (!o_valid && !busy),
        "reset did not clear sequencer")

endmodule
